// ===== design/ate_pkg.sv =====
// ----------------------------------------------------------------------------
// ate_pkg: arithmetic expression tokenizer definitions
// Character codes, token kinds and the queue entry shared by the block's parts.
// ----------------------------------------------------------------------------
package ate_pkg;

  localparam int DEFAULT_VALUE_BITS = 31;
  localparam int INT_W              = 31;
  localparam int QUEUE_DEPTH        = 4;
  localparam int QUEUE_AW           = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW           = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [1:0] {
    KIND_OP  = 2'd0,
    KIND_INT = 2'd1,
    KIND_EOF = 2'd2,
    KIND_BAD = 2'd3
  } kind_t;

  // Everything one character produces: an optional integer token followed by
  // an optional token of the character itself.
  typedef struct packed {
    logic             has_int;
    logic [INT_W-1:0] int_val;
    logic             int_ovf;
    logic             has_tok;
    kind_t            tok_kind;
    logic [7:0]       tok_char;
  } entry_t;

  function automatic logic is_operator(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
           (c == CH_SLASH) || (c == CH_LPAREN) || (c == CH_RPAREN);
  endfunction

endpackage

// ===== design/ate_if.sv =====
// ----------------------------------------------------------------------------
// ate_if: tokenizer channels
// Valid/ready channels for characters in and tokens out.
// ----------------------------------------------------------------------------
interface ate_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface ate_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  token_kind;
  logic [7:0]  op_char;
  logic [30:0] int_value;
  logic        overflow;
  logic        last_of_run;

  modport source (output valid, output token_kind, output op_char, output int_value,
                  output overflow, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input op_char, input int_value,
                  input overflow, input last_of_run, output ready);
endinterface

// ===== design/arith_expression_tokenizer.sv =====
// Each token is registered in the queue and then in the output register, and it waits
// in the queue while the output is stalled.
// Throughput: one character per cycle while the queue has room; a character that both
// ends a number and carries a token of its own yields two tokens, and a four-entry queue absorbs that.
// The rate is set by the combinational multiply-by-ten-and-add in the classifier.
// Reset: synchronous, active low; it clears the open number, the queue and the output.
// ----------------------------------------------------------------------------
// arith_expression_tokenizer: arithmetic expression lexer
// Turns a stream of characters into operator, integer, end-of-text and error
// tokens, one character per transaction in and one token per transaction out.
// ----------------------------------------------------------------------------
module arith_expression_tokenizer import ate_pkg::*; #(
  parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  ate_in_if.sink   in_ch,
  ate_out_if.source out_ch
);

  // The front end classifies every character as it arrives. Digits only update
  // the running number and produce nothing. Any other character closes an open
  // number and, unless it is a space, adds its own token; both go into a single
  // queue entry so that the pair always leaves in the right order.
  logic   accept;
  logic   push;
  entry_t push_entry;

  // Queue handshake between the two halves.
  logic   q_empty;
  logic   q_full;
  logic   pop;
  entry_t head;

  // Input is taken whenever the queue has room, independent of the output side.
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  ate_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .char_code (in_ch.char_code),
    .push      (push),
    .entry     (push_entry)
  );

  ate_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  // The back end holds the output register. It unpacks an entry into an integer
  // token first and the character's token next; last_of_run marks whichever is
  // the final one for that character.
  ate_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (q_empty),
    .head      (head),
    .pop       (pop),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_kind  (out_ch.token_kind),
    .out_char  (out_ch.op_char),
    .out_value (out_ch.int_value),
    .out_ovf   (out_ch.overflow),
    .out_last  (out_ch.last_of_run)
  );

endmodule

// ===== design/ate_front.sv =====
// ----------------------------------------------------------------------------
// ate_front: character classifier and number accumulator
// Classifies each accepted character, builds digit runs and forms queue entries.
// ----------------------------------------------------------------------------
module ate_front import ate_pkg::*; #(
  parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] char_code,
  output logic       push,
  output entry_t     entry
);

  logic                    in_number_r, in_number_nxt;
  logic [VALUE_BITS-1:0]   accum_r, accum_nxt;
  logic                    ovf_r, ovf_nxt;

  logic                    is_digit;
  logic [7:0]              digit_full;
  logic [3:0]              digit;
  logic [VALUE_BITS+3:0]   accum_ext;
  logic [VALUE_BITS+3:0]   scaled;
  logic                    sat;
  logic [VALUE_BITS+30:0]  accum_wide;

  assign is_digit   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign digit_full = char_code - CH_ZERO;
  assign digit      = digit_full[3:0];

  // value*10 + digit as two shifted adds, with four guard bits to spot saturation.
  assign accum_ext  = {4'b0000, accum_r};
  assign scaled     = (accum_ext << 3) + (accum_ext << 1) + {{VALUE_BITS{1'b0}}, digit};
  assign sat        = ovf_r || (|scaled[VALUE_BITS+3:VALUE_BITS]);
  assign accum_wide = {{INT_W{1'b0}}, accum_r};

  always_comb begin
    in_number_nxt = in_number_r;
    accum_nxt     = accum_r;
    ovf_nxt       = ovf_r;
    push          = 1'b0;

    entry.has_int  = in_number_r;
    entry.int_val  = accum_wide[INT_W-1:0];
    entry.int_ovf  = ovf_r;
    entry.has_tok  = 1'b1;
    entry.tok_kind = KIND_BAD;
    entry.tok_char = char_code;

    if (char_code == CH_SPACE) begin
      entry.has_tok = 1'b0;
    end else if (is_operator(char_code)) begin
      entry.tok_kind = KIND_OP;
    end else if (char_code == CH_NUL) begin
      entry.tok_kind = KIND_EOF;
      entry.tok_char = CH_NUL;
    end

    if (accept) begin
      if (is_digit) begin
        in_number_nxt = 1'b1;
        if (!in_number_r) begin
          accum_nxt = {{(VALUE_BITS-4){1'b0}}, digit};
          ovf_nxt   = 1'b0;
        end else if (sat) begin
          accum_nxt = {VALUE_BITS{1'b1}};
          ovf_nxt   = 1'b1;
        end else begin
          accum_nxt = scaled[VALUE_BITS-1:0];
        end
      end else begin
        push          = in_number_r || entry.has_tok;
        in_number_nxt = 1'b0;
        accum_nxt     = '0;
        ovf_nxt       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_number_r <= 1'b0;
      accum_r     <= '0;
      ovf_r       <= 1'b0;
    end else begin
      in_number_r <= in_number_nxt;
      accum_r     <= accum_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

endmodule

// ===== design/ate_queue.sv =====
// ----------------------------------------------------------------------------
// ate_queue: entry queue
// Short first-in first-out queue between the classifier and the token emitter.
// ----------------------------------------------------------------------------
module ate_queue import ate_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   empty,
  output logic   full
);

  entry_t              slots_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CW-1:0] count_r, count_nxt;
  logic                do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== design/ate_back.sv =====
// ----------------------------------------------------------------------------
// ate_back: token emitter
// Splits each queue entry into one or two tokens and drives the output register.
// ----------------------------------------------------------------------------
module ate_back import ate_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             empty,
  input  entry_t           head,
  output logic             pop,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_char,
  output logic [INT_W-1:0] out_value,
  output logic             out_ovf,
  output logic             out_last
);

  logic             valid_r, valid_nxt;
  logic             pend_r, pend_nxt;
  kind_t            pend_kind_r, pend_kind_nxt;
  logic [7:0]       pend_char_r, pend_char_nxt;
  kind_t            kind_r, kind_nxt;
  logic [7:0]       char_r, char_nxt;
  logic [INT_W-1:0] value_r, value_nxt;
  logic             ovf_r, ovf_nxt;
  logic             last_r, last_nxt;
  logic             load_ok;

  assign load_ok = !valid_r || out_ready;

  always_comb begin
    valid_nxt     = valid_r;
    pend_nxt      = pend_r;
    pend_kind_nxt = pend_kind_r;
    pend_char_nxt = pend_char_r;
    kind_nxt      = kind_r;
    char_nxt      = char_r;
    value_nxt     = value_r;
    ovf_nxt       = ovf_r;
    last_nxt      = last_r;
    pop           = 1'b0;

    if (load_ok) begin
      if (pend_r) begin
        // Second token of an entry whose integer has already gone out.
        valid_nxt = 1'b1;
        pend_nxt  = 1'b0;
        kind_nxt  = pend_kind_r;
        char_nxt  = pend_char_r;
        value_nxt = '0;
        ovf_nxt   = 1'b0;
        last_nxt  = 1'b1;
      end else if (!empty) begin
        pop       = 1'b1;
        valid_nxt = 1'b1;
        if (head.has_int) begin
          kind_nxt      = KIND_INT;
          char_nxt      = '0;
          value_nxt     = head.int_val;
          ovf_nxt       = head.int_ovf;
          last_nxt      = !head.has_tok;
          pend_nxt      = head.has_tok;
          pend_kind_nxt = head.tok_kind;
          pend_char_nxt = head.tok_char;
        end else begin
          kind_nxt  = head.tok_kind;
          char_nxt  = head.tok_char;
          value_nxt = '0;
          ovf_nxt   = 1'b0;
          last_nxt  = 1'b1;
        end
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_kind_r <= pend_kind_nxt;
    pend_char_r <= pend_char_nxt;
    kind_r      <= kind_nxt;
    char_r      <= char_nxt;
    value_r     <= value_nxt;
    ovf_r       <= ovf_nxt;
    last_r      <= last_nxt;
  end

  assign out_valid = valid_r;
  assign out_kind  = kind_r;
  assign out_char  = char_r;
  assign out_value = value_r;
  assign out_ovf   = ovf_r;
  assign out_last  = last_r;

endmodule

// ===== design/ate_checker.sv =====
// ----------------------------------------------------------------------------
// ate_checker: tokenizer port checks
// Observes the token channel and checks how tokens are formed and presented.
// ----------------------------------------------------------------------------
module ate_checker import ate_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_char,
  input logic [30:0] out_value,
  input logic        out_ovf,
  input logic        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_char) &&
      $stable(out_value) && $stable(out_ovf) && $stable(out_last))
    else $error("token changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("token presented straight after reset");

  a_non_int_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_INT) |-> (out_value == '0) && !out_ovf && out_last)
    else $error("non-integer token carries a value or is not last");

  a_int_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_kind == KIND_INT) || (out_kind == KIND_EOF)) |-> (out_char == '0))
    else $error("integer or end-of-text token carries a character");

  a_int_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_kind == KIND_INT) && !out_last |=>
      out_valid && (out_kind != KIND_INT))
    else $error("integer token not followed at once by its character token");

endmodule

bind arith_expression_tokenizer ate_checker u_ate_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.token_kind),
  .out_char  (out_ch.op_char),
  .out_value (out_ch.int_value),
  .out_ovf   (out_ch.overflow),
  .out_last  (out_ch.last_of_run)
);
